// ----- design/sccr_pkg.sv -----
// Shared types and command codes for the sector cache clock replacement core.
package sccr_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_SYNC  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] sector;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic        hit;
    logic        fill;
    logic        writeback;
    logic [31:0] writeback_sector;
    logic        last;
  } res_t;

  typedef struct packed {
    logic valid;
    logic accessed;
    logic dirty;
  } flags_t;

endpackage

// ----- design/sector_cache_clock_replacement_core.sv -----
// Top level: ring of slot cells plus the access, sweep and sync sequencer.
// Sequence: an access searches the whole ring, then rotates to its slot (or, on a
//   full cache, runs a clock sweep from the hand) and then brings the ring home.
// Sync passes every slot by the head; results stream out as dirty slots pass the head.
// One item at a time (busy high while working); results cannot be stalled.
// Reset (rst, synchronous) clears all valid, accessed and dirty marks and the hand.
module sector_cache_clock_replacement_core import sccr_pkg::*; #(
  parameter int SLOT_COUNT  = 64,
  parameter int SECTOR_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic res_valid,
  output res_t res
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_APPLY, S_SWEEP, S_UNWIND, S_SYNC, S_FLUSH
  } state_t;

  state_t state;

  // Ring: cell 0 is the head, the sequencer looks only there. A shift moves
  // every cell down by one and feeds the (possibly updated) head into the tail.
  logic [SECTOR_BITS-1:0] c_tag [SLOT_COUNT];
  flags_t                 c_flg [SLOT_COUNT];
  logic                   shift;
  logic [SECTOR_BITS-1:0] tail_tag;
  flags_t                 tail_flg;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    logic [SECTOR_BITS-1:0] t_in;
    flags_t                 f_in;
    if (i == SLOT_COUNT - 1) begin : g_tail
      assign t_in = tail_tag;
      assign f_in = tail_flg;
    end else begin : g_mid
      assign t_in = c_tag[i+1];
      assign f_in = c_flg[i+1];
    end
    sccr_cell #(.SECTOR_BITS(SECTOR_BITS)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (shift),
      .tag_in (t_in),
      .flg_in (f_in),
      .tag    (c_tag[i]),
      .flg    (c_flg[i])
    );
  end

  logic [SECTOR_BITS-1:0] head_tag;
  flags_t                 head_flg;
  assign head_tag = c_tag[0];
  assign head_flg = c_flg[0];

  // Sequencer registers
  logic [IW-1:0]          rot;      // slot index now sitting at the head
  logic [IW-1:0]          hand;
  logic [IW-1:0]          target;
  logic                   is_write;
  logic [SECTOR_BITS-1:0] sec;
  logic                   found;
  logic                   have_free;
  logic [IW-1:0]          hit_slot;
  logic [IW-1:0]          free_slot;
  logic                   pend_valid;
  logic [IW-1:0]          pend_slot;
  logic [SECTOR_BITS-1:0] pend_tag;

  logic [IW-1:0] rot_inc, hand_inc;
  assign rot_inc  = (rot == LAST_IDX) ? '0 : rot + 1'b1;
  assign hand_inc = (hand == LAST_IDX) ? '0 : hand + 1'b1;

  // Width adaption of the external fields
  logic [SECTOR_BITS+31:0] sec_wide;
  logic [SECTOR_BITS-1:0]  sec_in;
  assign sec_wide = {{SECTOR_BITS{1'b0}}, cmd.sector};
  assign sec_in   = sec_wide[SECTOR_BITS-1:0];

  logic [IW+5:0] slot_wide;
  logic [SECTOR_BITS+31:0] wbs_wide;
  logic [IW-1:0] emit_idx;
  logic [SECTOR_BITS-1:0] emit_tag;

  // Search bookkeeping including the current head
  logic          head_hit;
  logic          found_c, free_c;
  logic [IW-1:0] hit_c, free_slot_c;
  always_comb begin
    head_hit    = head_flg.valid && (head_tag == sec);
    found_c     = found;
    hit_c       = hit_slot;
    free_c      = have_free;
    free_slot_c = free_slot;
    if (head_hit) begin
      found_c = 1'b1;
      hit_c   = rot;
    end
    if (!head_flg.valid && !have_free) begin
      free_c      = 1'b1;
      free_slot_c = rot;
    end
  end

  // Head update and result generation
  logic emit;
  logic emit_hit, emit_fill, emit_wb, emit_last;
  always_comb begin
    shift     = 1'b0;
    tail_tag  = head_tag;
    tail_flg  = head_flg;
    emit      = 1'b0;
    emit_idx  = rot;
    emit_tag  = '0;
    emit_hit  = 1'b0;
    emit_fill = 1'b0;
    emit_wb   = 1'b0;
    emit_last = 1'b1;
    case (state)
      S_SEARCH: shift = 1'b1;
      S_APPLY: begin
        shift = 1'b1;
        if (rot == target) begin
          emit = 1'b1;
          if (found) begin
            tail_flg.accessed = 1'b1;
            tail_flg.dirty    = head_flg.dirty | is_write;
            emit_hit          = 1'b1;
          end else begin
            tail_tag  = sec;
            tail_flg  = '{valid: 1'b1, accessed: 1'b1, dirty: is_write};
            emit_fill = 1'b1;
          end
        end
      end
      S_SWEEP: begin
        shift = 1'b1;
        if (rot == hand) begin
          if (head_flg.accessed) begin
            tail_flg.accessed = 1'b0;   // second chance
          end else begin
            emit      = 1'b1;
            emit_fill = 1'b1;
            emit_wb   = head_flg.dirty;
            emit_tag  = head_flg.dirty ? head_tag : '0;
            tail_tag  = sec;
            tail_flg  = '{valid: 1'b1, accessed: 1'b1, dirty: is_write};
          end
        end
      end
      S_UNWIND: shift = (rot != '0);
      S_SYNC: begin
        shift          = 1'b1;
        tail_flg.dirty = 1'b0;
        if (head_flg.dirty && pend_valid) begin
          emit      = 1'b1;
          emit_idx  = pend_slot;
          emit_tag  = pend_tag;
          emit_wb   = 1'b1;
          emit_last = 1'b0;
        end
      end
      S_FLUSH: begin
        if (pend_valid) begin
          emit     = 1'b1;
          emit_idx = pend_slot;
          emit_tag = pend_tag;
          emit_wb  = 1'b1;
        end
      end
      default: shift = 1'b0;
    endcase
  end

  assign slot_wide = {6'b0, emit_idx};
  assign wbs_wide  = {32'b0, emit_tag};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rot        <= '0;
      hand       <= '0;
      found      <= 1'b0;
      have_free  <= 1'b0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= emit;
      if (emit) begin
        res.slot             <= slot_wide[5:0];
        res.hit              <= emit_hit;
        res.fill             <= emit_fill;
        res.writeback        <= emit_wb;
        res.writeback_sector <= wbs_wide[31:0];
        res.last             <= emit_last;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            sec        <= sec_in;
            is_write   <= (cmd.command == CMD_WRITE);
            found      <= 1'b0;
            have_free  <= 1'b0;
            pend_valid <= 1'b0;
            case (cmd.command)
              CMD_READ, CMD_WRITE: state <= S_SEARCH;
              CMD_SYNC:            state <= S_SYNC;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_SEARCH: begin
          rot       <= rot_inc;
          found     <= found_c;
          hit_slot  <= hit_c;
          have_free <= free_c;
          free_slot <= free_slot_c;
          if (rot == LAST_IDX) begin
            if (found_c) begin
              target <= hit_c;
              state  <= S_APPLY;
            end else if (free_c) begin
              target <= free_slot_c;
              state  <= S_APPLY;
            end else begin
              state <= S_SWEEP;
            end
          end
        end
        S_APPLY: begin
          rot <= rot_inc;
          if (rot == target) state <= S_UNWIND;
        end
        S_SWEEP: begin
          rot <= rot_inc;
          if (rot == hand) begin
            if (head_flg.accessed) hand <= hand_inc;
            else state <= S_UNWIND;   // hand stays on the victim
          end
        end
        S_UNWIND: begin
          if (rot != '0) rot <= rot_inc;
          else state <= S_IDLE;
        end
        S_SYNC: begin
          rot <= rot_inc;
          if (head_flg.dirty) begin
            pend_valid <= 1'b1;
            pend_slot  <= rot;
            pend_tag   <= head_tag;
          end
          if (rot == LAST_IDX) state <= S_FLUSH;
        end
        S_FLUSH: begin
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // Ring is always home when idle
  a_home: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (rot == '0))
    else $error("ring not home while idle");

  // An access transfer always starts work
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.command == CMD_READ || cmd.command == CMD_WRITE)) |=> busy)
    else $error("access not taken");

  // Hit and fill are exclusive
  a_hitfill: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.hit && res.fill))
    else $error("hit and fill together");

  // No write-back sector without write-back
  a_wbs: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.writeback) |-> (res.writeback_sector == '0))
    else $error("stray write-back sector");

endmodule

// ----- design/sccr_cell.sv -----
// One slot cell of the rotating tag ring.
module sccr_cell import sccr_pkg::*; #(
  parameter int SECTOR_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic [SECTOR_BITS-1:0] tag_in,
  input  flags_t                 flg_in,
  output logic [SECTOR_BITS-1:0] tag,
  output flags_t                 flg
);

  always_ff @(posedge clk) begin
    if (shift) begin
      tag <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flg <= '0;
    end else if (shift) begin
      flg <= flg_in;
    end
  end

endmodule
